// File: rtl/core/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
package lpg_pkg;

  localparam int COORD_BITS  = 6;
  // Decision value spans -2*max_delta .. +2*max_delta, plus a sign bit
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Line request as it arrives
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } lpg_req_t;

  // One pixel of the run
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } lpg_pix_t;

  // Classified line, ready for the stepper
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t big;
    coord_t small_d;
    logic   x_major;
    logic   x_neg;
    logic   y_neg;
    dec_t   p_init;
  } lpg_line_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lpg_state_t;

endpackage

// File: rtl/core/line_pixel_generator_core.sv
// Line pixel generator: takes a line request from a start point to an end point and
// emits every pixel of the line, start to end, by the integer Bresenham rule; the last
// pixel carries last_pixel. A line with major delta D gives D+1 pixels: the stepper
// loads the line from the queue while idle, then emits one pixel per cycle while the
// output is not stalled, and returns to idle after the last pixel. A classify stage
// and a two-entry queue in front of the stepper take up to three further requests
// while a line is being drawn, and the output register lets a new pixel be produced
// in the same cycle the previous one is taken.
module line_pixel_generator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpg_pkg::lpg_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output lpg_pkg::lpg_pix_t out_pix
);
  import lpg_pkg::*;

  logic      f_push;
  logic      f_ready;
  lpg_line_t f_line;
  logic      q_valid;
  logic      q_pop;
  lpg_line_t q_line;

  lpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_push   (f_push),
    .q_ready  (f_ready),
    .q_line   (f_line)
  );

  lpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_ready (f_ready),
    .push_line  (f_line),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_line   (q_line)
  );

  lpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_line    (q_line),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix)
  );

endmodule

// File: rtl/core/lpg_front.sv
// Front end: takes line requests and classifies them (deltas, major axis, directions).
module lpg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpg_pkg::lpg_req_t in_req,
  output logic              q_push,
  input  logic              q_ready,
  output lpg_pkg::lpg_line_t q_line
);
  import lpg_pkg::*;

  lpg_line_t cls;
  lpg_line_t rec;
  logic      rec_valid;
  logic      x_fwd;
  logic      y_fwd;
  coord_t    adx;
  coord_t    ady;
  logic      x_major;
  coord_t    big;
  coord_t    small_d;

  // Absolute deltas, step directions and major axis
  always_comb begin
    x_fwd   = in_req.end_x >= in_req.start_x;
    y_fwd   = in_req.end_y >= in_req.start_y;
    adx     = x_fwd ? (in_req.end_x - in_req.start_x) : (in_req.start_x - in_req.end_x);
    ady     = y_fwd ? (in_req.end_y - in_req.start_y) : (in_req.start_y - in_req.end_y);
    x_major = adx >= ady;
    big     = x_major ? adx : ady;
    small_d = x_major ? ady : adx;

    cls.start_x = in_req.start_x;
    cls.start_y = in_req.start_y;
    cls.end_x   = in_req.end_x;
    cls.end_y   = in_req.end_y;
    cls.big     = big;
    cls.small_d = small_d;
    cls.x_major = x_major;
    cls.x_neg   = !x_fwd;
    cls.y_neg   = !y_fwd;
    // p0 = 2*minor - major
    cls.p_init  = dec_t'({2'b00, small_d, 1'b0}) - dec_t'({3'b000, big});
  end

  assign in_ready = !rec_valid || q_ready;
  assign q_push   = rec_valid;
  assign q_line   = rec;

  // Classified request register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      rec_valid <= 1'b1;
    end else if (q_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rec <= cls;
    end
  end

endmodule

// File: rtl/core/lpg_queue.sv
// Short queue of classified lines between the front end and the stepper.
module lpg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               push_ready,
  input  lpg_pkg::lpg_line_t push_line,
  output logic               pop_valid,
  input  logic               pop,
  output lpg_pkg::lpg_line_t pop_line
);
  import lpg_pkg::*;

  lpg_line_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_line   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_line;
    end
  end

endmodule

// File: rtl/core/lpg_back.sv
// Back end: Bresenham stepper, one pixel per cycle into an output register unless stalled.
module lpg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  lpg_pkg::lpg_line_t q_line,
  output logic               out_valid,
  input  logic               out_ready,
  output lpg_pkg::lpg_pix_t  out_pix
);
  import lpg_pkg::*;

  lpg_state_t state;
  lpg_state_t state_next;
  coord_t     cx;
  coord_t     cy;
  coord_t     end_x;
  coord_t     end_y;
  coord_t     remaining;
  coord_t     big;
  coord_t     small_d;
  logic       x_major;
  logic       x_neg;
  logic       y_neg;
  dec_t       p;
  dec_t       two_big;
  dec_t       two_small;
  dec_t       p_next;
  logic       p_pos;
  logic       emit;
  logic       last;
  coord_t     cx_next;
  coord_t     cy_next;
  lpg_pix_t   pix;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (state)
      ST_IDLE: q_pop = q_valid;
      ST_RUN:  emit  = !out_valid || out_ready;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  // Decision update and coordinate step
  always_comb begin
    last      = remaining == '0;
    two_big   = dec_t'({2'b00, big, 1'b0});
    two_small = dec_t'({2'b00, small_d, 1'b0});
    p_pos     = !p[DEC_BITS-1] && (p != '0);
    p_next    = p_pos ? (p - two_big + two_small) : (p + two_small);
    cx_next   = cx;
    cy_next   = cy;
    if (x_major || p_pos) begin
      cx_next = x_neg ? cx - 1'b1 : cx + 1'b1;
    end
    if (!x_major || p_pos) begin
      cy_next = y_neg ? cy - 1'b1 : cy + 1'b1;
    end
    pix.pixel_x    = cx;
    pix.pixel_y    = cy;
    pix.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Line registers: load from the queue, then step once per emitted pixel
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx        <= q_line.start_x;
      cy        <= q_line.start_y;
      end_x     <= q_line.end_x;
      end_y     <= q_line.end_y;
      remaining <= q_line.big;
      big       <= q_line.big;
      small_d   <= q_line.small_d;
      x_major   <= q_line.x_major;
      x_neg     <= q_line.x_neg;
      y_neg     <= q_line.y_neg;
      p         <= q_line.p_init;
    end else if (emit) begin
      cx        <= cx_next;
      cy        <= cy_next;
      p         <= p_next;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix <= pix;
    end
  end

`ifndef NO_ASSERTIONS
  // The run must land exactly on the end point
  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |-> (cx == end_x && cy == end_y))
    else $error("last pixel is not the end point");

  // Decision value stays in -2*major .. 2*minor while drawing
  a_p_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (p <= two_small && p >= -two_big))
    else $error("decision value out of range");

  // A new line is only taken once the previous run has finished
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> (state == ST_IDLE && !emit))
    else $error("stepper did not return to idle after last pixel");

  // On an x-major line, the minor coordinate never steps past the end row
  a_minor_dir: assert property (@(posedge clk) disable iff (rst)
    (emit && !last && x_major && p_pos) |-> (cy != end_y))
    else $error("minor step past the end row");
`endif

endmodule

// File: tb/line_pixel_generator_core_test.sv
// Testbench for the line pixel generator core: directed and random line requests
`timescale 1ns / 1ps

module line_pixel_generator_core_test;
  import lpg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_LINES  = 386;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_ROWS    = 24;

  // Directed requests: start x/y, end x/y, typed pixel count (0 = predicted),
  // then first and second typed pixel; the last typed pixel carries last_pixel
  localparam int DIR_TAB [DIR_ROWS][9] = '{
    '{ 0,  0,  0,  0, 1,  0,  0, 0, 0},  // single point at origin
    '{63, 63, 63, 63, 1, 63, 63, 0, 0},  // single point at far corner
    '{ 0, 63,  0, 63, 1,  0, 63, 0, 0},
    '{63,  0, 63,  0, 1, 63,  0, 0, 0},
    '{ 0,  0,  1,  1, 2,  0,  0, 1, 1},  // one diagonal step
    '{63, 63, 62, 62, 2, 63, 63, 62, 62},
    '{10, 10, 11, 10, 2, 10, 10, 11, 10},
    '{20, 20, 20, 19, 2, 20, 20, 20, 19},
    '{ 0,  0, 63,  0, 0,  0,  0, 0, 0},  // full-width horizontal, both ways
    '{63,  0,  0,  0, 0,  0,  0, 0, 0},
    '{ 0,  0,  0, 63, 0,  0,  0, 0, 0},  // full-height vertical, both ways
    '{ 0, 63,  0,  0, 0,  0,  0, 0, 0},
    '{ 0,  0, 63, 63, 0,  0,  0, 0, 0},  // equal deltas in all four quadrants
    '{63, 63,  0,  0, 0,  0,  0, 0, 0},
    '{63,  0,  0, 63, 0,  0,  0, 0, 0},
    '{ 0, 63, 63,  0, 0,  0,  0, 0, 0},
    '{ 0,  0, 63, 10, 0,  0,  0, 0, 0},  // shallow
    '{63, 63, 10,  0, 0,  0,  0, 0, 0},
    '{ 0,  0, 10, 63, 0,  0,  0, 0, 0},  // steep
    '{40,  5,  2, 30, 0,  0,  0, 0, 0},
    '{ 0,  0,  4,  2, 0,  0,  0, 0, 0},  // decision hits exactly zero
    '{ 5,  5,  8,  2, 0,  0,  0, 0, 0},
    '{30, 30,  1, 62, 0,  0,  0, 0, 0},
    '{63,  0,  0,  1, 0,  0,  0, 0, 0}
  };

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  lpg_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  lpg_pix_t out_pix;

  lpg_pix_t pixel_q[$];
  int       mismatches;
  int       stall_cnt;
  int       src_idle_pct;
  int       dst_idle_pct;

  line_pixel_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pix  (out_pix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected pixels of one line, start to end, by the Bresenham decision rule
  function automatic void plot_line(lpg_req_t r);
    int       x0, y0, x1, y1;
    int       adx, ady, sx, sy;
    int       major_d, minor_d, dec;
    int       cx, cy;
    bit       x_major;
    lpg_pix_t px;
    x0 = r.start_x;
    y0 = r.start_y;
    x1 = r.end_x;
    y1 = r.end_y;
    adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    sx = (x1 >= x0) ? 1 : -1;
    sy = (y1 >= y0) ? 1 : -1;
    x_major = (adx >= ady);
    major_d = x_major ? adx : ady;
    minor_d = x_major ? ady : adx;
    dec = 2 * minor_d - major_d;
    cx = x0;
    cy = y0;
    for (int k = 0; k <= major_d; k++) begin
      px.pixel_x    = coord_t'(cx);
      px.pixel_y    = coord_t'(cy);
      px.last_pixel = (k == major_d);
      pixel_q.push_back(px);
      if (x_major) cx += sx;
      else cy += sy;
      if (dec > 0) begin
        if (x_major) cy += sy;
        else cx += sx;
        dec -= 2 * major_d;
      end
      dec += 2 * minor_d;
    end
  endfunction

  // Offset a coordinate, held inside the grid
  function automatic coord_t nudge(coord_t c, int off);
    int v;
    v = int'(c) + off;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  // Random line: full range, short runs, axis/diagonal runs, or slope-half ties
  function automatic lpg_req_t random_line();
    lpg_req_t r;
    int       len;
    r = lpg_req_t'({$urandom, $urandom});
    len = $urandom_range(63);
    case ($urandom_range(3))
      0: ;
      1: begin
        r.end_x = nudge(r.start_x, $urandom_range(6) - 3);
        r.end_y = nudge(r.start_y, $urandom_range(6) - 3);
      end
      2: begin
        r.end_x = nudge(r.start_x, ($urandom_range(2) - 1) * len);
        r.end_y = nudge(r.start_y, ($urandom_range(2) - 1) * len);
      end
      default: begin
        len = $urandom_range(31);
        r.end_x = nudge(r.start_x, $urandom_range(1) ? 2 * len : -2 * len);
        r.end_y = nudge(r.start_y, $urandom_range(1) ? len : -len);
      end
    endcase
    return r;
  endfunction

  // Present one request and hold it until it is taken
  task automatic send_line(lpg_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pixel side: check each taken pixel, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel x=%0d y=%0d last=%0b",
                   out_pix.pixel_x, out_pix.pixel_y, out_pix.last_pixel);
      end else begin
        if (out_pix !== pixel_q[0]) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     pixel_q[0].pixel_x, pixel_q[0].pixel_y, pixel_q[0].last_pixel,
                     out_pix.pixel_x, out_pix.pixel_y, out_pix.last_pixel);
        end
        void'(pixel_q.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    lpg_req_t r;
    lpg_pix_t px;
    mismatches   = 0;
    stall_cnt    = 0;
    src_idle_pct = 7;
    dst_idle_pct = 50;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_req       = '0;
    out_ready    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests
    for (int i = 0; i < DIR_ROWS; i++) begin
      r.start_x = coord_t'(DIR_TAB[i][0]);
      r.start_y = coord_t'(DIR_TAB[i][1]);
      r.end_x   = coord_t'(DIR_TAB[i][2]);
      r.end_y   = coord_t'(DIR_TAB[i][3]);
      send_line(r);
      if (DIR_TAB[i][4] == 0) begin
        plot_line(r);
      end else begin
        for (int j = 0; j < DIR_TAB[i][4]; j++) begin
          px.pixel_x    = coord_t'(DIR_TAB[i][5 + 2 * j]);
          px.pixel_y    = coord_t'(DIR_TAB[i][6 + 2 * j]);
          px.last_pixel = (j == DIR_TAB[i][4] - 1);
          pixel_q.push_back(px);
        end
      end
    end

    // Random requests in three idling phases
    for (int i = 0; i < RAND_LINES; i++) begin
      if (i == RAND_LINES / 3) begin
        src_idle_pct = 50;
        dst_idle_pct = 7;
      end else if (i == 2 * RAND_LINES / 3) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      r = random_line();
      send_line(r);
      plot_line(r);
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray pixels
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pixel_q.size();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
